// ===== design/fscc_pkg.sv =====
// Package: widths, reset values, register indexes and status codes of the fixed-step clock.
package fscc_pkg;

   localparam int unsigned ELAPSED_W = 64;
   localparam int unsigned TIME_W    = 63;
   localparam int unsigned TICK_W    = 64;
   localparam int unsigned RUN_W     = 16;
   localparam int unsigned STATUS_W  = 2;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DAT_W = 63;

   localparam logic [TIME_W-1:0] STEP_RESET  = TIME_W'(1000000);
   localparam logic [RUN_W-1:0]  LIMIT_RESET = RUN_W'(8);

   localparam logic [CSR_IDX_W-1:0] CSR_STEP  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NEGATIVE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TIME_OVF = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_TICK_OVF = 2'd3;

endpackage

// ===== design/fscc_if.sv =====
// Interfaces: request and response channels of the fixed-step clock.
interface fscc_req_if import fscc_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [ELAPSED_W-1:0] elapsed_ns;

   modport source (output valid, output elapsed_ns, input ready);
   modport sink   (input valid, input elapsed_ns, output ready);
endinterface

interface fscc_rsp_if import fscc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [TICK_W-1:0]   first_tick;
   logic [RUN_W-1:0]    ticks_run;
   logic [TIME_W-1:0]   leftover_ns;
   logic [TIME_W-1:0]   dropped_ns;

   modport source (output valid, output status, output first_tick, output ticks_run,
                   output leftover_ns, output dropped_ns, input ready);
   modport sink   (input valid, input status, input first_tick, input ticks_run,
                   input leftover_ns, input dropped_ns, output ready);
endinterface

// ===== design/fixed_step_catch_up_clock.sv =====
// Top level: fixed-step simulation clock with catch-up limit, iterative divide and multiply.
//
//   channel  | dir | transfer when        | carries
//   ---------+-----+----------------------+---------------------------------------------
//   req_if   | in  | valid & ready        | elapsed_ns (signed 64)
//   rsp_if   | out | valid & ready        | status, first_tick, ticks_run, leftover_ns,
//            |     |                      | dropped_ns
//   csr_*    | in  | csr_we               | step_ns (idx 0), catch_up_limit (idx 1)
//
// Steps: an error on the sign or the sum goes from idle straight to the output state;
// a good item passes the restoring divider (one quotient bit a cycle), the check, where
// a tick overflow is caught, and the shift-add multiply (one bit of ticks_run a cycle).
// Reset clears the carried time and tick counter and loads the register defaults.
// req_if.ready is high only in idle; the response register parts the two sides, so a
// new request may be taken while the previous response still waits for rsp_if.ready.
module fixed_step_catch_up_clock import fscc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   fscc_req_if.sink             req_if,
   fscc_rsp_if.source           rsp_if,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_CHECK,
      ST_MUL,
      ST_OUT
   } state_type;

   localparam int unsigned CNT_W = $clog2(TIME_W);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(TIME_W - 1);
   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(RUN_W - 1);

   // configuration and architectural state
   logic [TIME_W-1:0]   step_ff,    step_in;
   logic [RUN_W-1:0]    limit_ff,   limit_in;
   logic [TIME_W-1:0]   carried_ff, carried_in;
   logic [TICK_W-1:0]   ticks_ff,   ticks_in;

   // sequencer and datapath
   state_type           state_ff,   state_in;
   logic [CNT_W-1:0]    cnt_ff,     cnt_in;
   logic [TIME_W-1:0]   quo_ff,     quo_in;   // dividend shifts out, quotient shifts in
   logic [TIME_W-1:0]   rem_ff,     rem_in;
   logic [TIME_W-1:0]   tot_ff,     tot_in;
   logic [TIME_W-1:0]   base_ff,    base_in;  // avail * step
   logic [TIME_W-1:0]   prod_ff,    prod_in;  // run * step
   logic [RUN_W-1:0]    run_ff,     run_in;
   logic [RUN_W-1:0]    msh_ff,     msh_in;   // multiplier bits, MSB first
   logic [TICK_W-1:0]   first_ff,   first_in;
   logic [STATUS_W-1:0] status_ff,  status_in;

   // response register
   logic                rsp_valid_ff,  rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [TICK_W-1:0]   rsp_first_ff,  rsp_first_in;
   logic [RUN_W-1:0]    rsp_run_ff,    rsp_run_in;
   logic [TIME_W-1:0]   rsp_left_ff,   rsp_left_in;
   logic [TIME_W-1:0]   rsp_drop_ff,   rsp_drop_in;

   logic                req_take;
   logic [TIME_W:0]     sum;
   logic [TIME_W:0]     shifted;
   logic [TIME_W+1:0]   diff;
   logic [RUN_W-1:0]    run_clamp;
   logic [TICK_W:0]     tick_sum;
   logic                out_free;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_take     = req_if.valid && (state_ff == ST_IDLE);
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.first_tick  = rsp_first_ff;
   assign rsp_if.ticks_run   = rsp_run_ff;
   assign rsp_if.leftover_ns = rsp_left_ff;
   assign rsp_if.dropped_ns  = rsp_drop_ff;

   // shared datapath terms
   assign sum      = {1'b0, carried_ff} + {1'b0, req_if.elapsed_ns[TIME_W-1:0]};
   assign shifted  = {rem_ff, quo_ff[TIME_W-1]};
   assign diff     = {1'b0, shifted} - {2'b00, step_ff};
   assign run_clamp = (quo_ff < {{(TIME_W-RUN_W){1'b0}}, limit_ff}) ? quo_ff[RUN_W-1:0]
                                                                     : limit_ff;
   assign tick_sum = {1'b0, ticks_ff} + {{(TICK_W+1-RUN_W){1'b0}}, run_clamp};

   always_comb begin
      step_in       = step_ff;
      limit_in      = limit_ff;
      carried_in    = carried_ff;
      ticks_in      = ticks_ff;
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      tot_in        = tot_ff;
      base_in       = base_ff;
      prod_in       = prod_ff;
      run_in        = run_ff;
      msh_in        = msh_ff;
      first_in      = first_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_run_in    = rsp_run_ff;
      rsp_left_in   = rsp_left_ff;
      rsp_drop_in   = rsp_drop_ff;

      // register writes; zero writes are ignored
      if (csr_we) begin
         unique case (csr_index)
            CSR_STEP:  if (csr_wdata != '0) step_in = csr_wdata[TIME_W-1:0];
            CSR_LIMIT: if (csr_wdata[RUN_W-1:0] != '0) limit_in = csr_wdata[RUN_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               priority if (req_if.elapsed_ns[ELAPSED_W-1]) begin
                  status_in = STATUS_NEGATIVE;
                  state_in  = ST_OUT;
               end else if (sum[TIME_W]) begin
                  status_in = STATUS_TIME_OVF;
                  state_in  = ST_OUT;
               end else begin
                  quo_in   = sum[TIME_W-1:0];
                  tot_in   = sum[TIME_W-1:0];
                  rem_in   = '0;
                  cnt_in   = '0;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            // one restoring step: keep the difference when it did not borrow
            if (!diff[TIME_W+1]) begin
               rem_in = diff[TIME_W-1:0];
            end else begin
               rem_in = shifted[TIME_W-1:0];
            end
            quo_in = {quo_ff[TIME_W-2:0], !diff[TIME_W+1]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (tick_sum[TICK_W]) begin
               status_in = STATUS_TICK_OVF;
               state_in  = ST_OUT;
            end else begin
               status_in  = STATUS_OK;
               run_in     = run_clamp;
               msh_in     = run_clamp;
               first_in   = ticks_ff;
               ticks_in   = tick_sum[TICK_W-1:0];
               carried_in = rem_ff;
               base_in    = tot_ff - rem_ff;
               prod_in    = '0;
               cnt_in     = '0;
               state_in   = ST_MUL;
            end
         end
         ST_MUL: begin
            // partial products never exceed run * step, which fits the time width
            prod_in = {prod_ff[TIME_W-2:0], 1'b0}
                    + (msh_ff[RUN_W-1] ? step_ff : {TIME_W{1'b0}});
            msh_in  = {msh_ff[RUN_W-2:0], 1'b0};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == MUL_LAST) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               if (status_ff == STATUS_OK) begin
                  rsp_first_in = first_ff;
                  rsp_run_in   = run_ff;
                  rsp_left_in  = rem_ff;
                  rsp_drop_in  = base_ff - prod_ff;
               end else begin
                  rsp_first_in = '0;
                  rsp_run_in   = '0;
                  rsp_left_in  = '0;
                  rsp_drop_in  = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_RESET;
         limit_ff     <= LIMIT_RESET;
         carried_ff   <= '0;
         ticks_ff     <= '0;
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         status_ff    <= STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         limit_ff     <= limit_in;
         carried_ff   <= carried_in;
         ticks_ff     <= ticks_in;
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      tot_ff        <= tot_in;
      base_ff       <= base_in;
      prod_ff       <= prod_in;
      run_ff        <= run_in;
      msh_ff        <= msh_in;
      first_ff      <= first_in;
      rsp_status_ff <= rsp_status_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_run_ff    <= rsp_run_in;
      rsp_left_ff   <= rsp_left_in;
      rsp_drop_ff   <= rsp_drop_in;
   end

endmodule
